### sv/stw_pkg.sv
// ----------------------------------------------------------------------------
// stw_pkg
// Shared types and constants for the section table walk unit.
// ----------------------------------------------------------------------------
package stw_pkg;

  localparam int unsigned VaddrWidth = 32;
  localparam int unsigned PaddrWidth = 40;
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [VaddrWidth-1:0] NoTable = '1;

  localparam logic [CfgIndexWidth-1:0] CfgMmuEnable = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgTableBase = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgSplitN = 2'd2;

  localparam logic FuncTranslate = 1'b0;
  localparam logic FuncDescriptor = 1'b1;

  localparam logic KindFetch = 1'b0;
  localparam logic KindDone = 1'b1;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusMmuOff = 2'd1;
  localparam logic [1:0] StatusNoTable = 2'd2;
  localparam logic [1:0] StatusFault = 2'd3;

  localparam logic [1:0] DescSection = 2'd2;

  typedef struct packed {
    logic mmu_enable;
    logic [31:0] table_base;
    logic [2:0] split_n;
  } cfg_t;

  typedef struct packed {
    logic func;
    logic [31:0] vaddr;
    logic [31:0] descriptor;
  } req_t;

  typedef struct packed {
    logic kind;
    logic [31:0] fetch_addr;
    logic [39:0] phys_addr;
    logic [1:0] status;
    logic [3:0] domain;
    logic [2:0] access_perm;
    logic [4:0] memory_attr;
    logic [3:0] extra_flags;
  } rsp_t;

endpackage

### sv/stw_cfg_regs.sv
// ----------------------------------------------------------------------------
// stw_cfg_regs
// Configuration registers: MMU enable, table base and split control.
// ----------------------------------------------------------------------------
module stw_cfg_regs (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [stw_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [stw_pkg::CfgDataWidth-1:0] cfg_data,
  output stw_pkg::cfg_t cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mmu_enable <= 1'b0;
      cfg.table_base <= stw_pkg::NoTable;
      cfg.split_n <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        stw_pkg::CfgMmuEnable: cfg.mmu_enable <= cfg_data[0];
        stw_pkg::CfgTableBase: cfg.table_base <= cfg_data;
        stw_pkg::CfgSplitN: cfg.split_n <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/stw_walk.sv
// ----------------------------------------------------------------------------
// stw_walk
// Walk state and result logic: builds the descriptor fetch address, decodes a
// returned descriptor into the translated address or passes vaddr through.
// ----------------------------------------------------------------------------
module stw_walk (
  input  logic clk,
  input  logic rst,
  input  stw_pkg::cfg_t cfg,
  input  stw_pkg::req_t req,
  input  logic transfer,
  output stw_pkg::rsp_t rsp,
  output logic has_rsp
);

  logic [31:0] pending_vaddr;
  logic awaiting_descriptor;
  logic [31:0] pending_vaddr_next;
  logic awaiting_descriptor_next;

  logic [31:0] base_mask;
  logic [11:0] idx_mask;
  logic [11:0] idx;
  logic [31:0] d;

  always_comb begin
    base_mask = 32'hFFFF_FFFF << (4'd14 - {1'b0, cfg.split_n});
    idx_mask = 12'hFFF >> cfg.split_n;
    idx = req.vaddr[31:20] & idx_mask;
    d = req.descriptor;

    rsp = '0;
    has_rsp = 1'b1;
    pending_vaddr_next = pending_vaddr;
    awaiting_descriptor_next = awaiting_descriptor;

    if (req.func == stw_pkg::FuncDescriptor) begin
      has_rsp = awaiting_descriptor;
      awaiting_descriptor_next = 1'b0;
      rsp.kind = stw_pkg::KindDone;
      if (d[1:0] != stw_pkg::DescSection) begin
        rsp.status = stw_pkg::StatusFault;
      end else begin
        rsp.status = stw_pkg::StatusOk;
        if (d[18]) begin
          rsp.phys_addr = {d[8:5], d[23:20], d[31:24], pending_vaddr[23:0]};
        end else begin
          rsp.phys_addr = {8'd0, d[31:20], pending_vaddr[19:0]};
          rsp.domain = d[8:5];
        end
        rsp.access_perm = {d[15], d[11:10]};
        rsp.memory_attr = {d[14:12], d[3], d[2]};
        rsp.extra_flags = {d[4], d[16], d[17], d[9]};
      end
    end else if (!cfg.mmu_enable) begin
      awaiting_descriptor_next = 1'b0;
      rsp.kind = stw_pkg::KindDone;
      rsp.phys_addr = {8'd0, req.vaddr};
      rsp.status = stw_pkg::StatusMmuOff;
    end else if (cfg.table_base == stw_pkg::NoTable) begin
      awaiting_descriptor_next = 1'b0;
      rsp.kind = stw_pkg::KindDone;
      rsp.phys_addr = {8'd0, req.vaddr};
      rsp.status = stw_pkg::StatusNoTable;
    end else begin
      pending_vaddr_next = req.vaddr;
      awaiting_descriptor_next = 1'b1;
      rsp.kind = stw_pkg::KindFetch;
      rsp.fetch_addr = (cfg.table_base & base_mask) | {18'd0, idx, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_vaddr <= '0;
      awaiting_descriptor <= 1'b0;
    end else if (transfer) begin
      pending_vaddr <= pending_vaddr_next;
      awaiting_descriptor <= awaiting_descriptor_next;
    end
  end

endmodule

### sv/section_table_walk_unit.sv
// ----------------------------------------------------------------------------
// section_table_walk_unit
// First-level section and supersection table walker with a registered
// result stage.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  stw_pkg::req_t
//   rsp      out        rsp_valid / rsp_ready  stw_pkg::rsp_t
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle while req_ready is high; a result appears in the cycle after its request transfer.
// The result register sets the rate: req_ready is high while it is empty or
// being drained in the same cycle.
// A descriptor with no walk outstanding gives no result.
// Reset clears the walk state and loads the register reset values.
// ----------------------------------------------------------------------------
module section_table_walk_unit (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  stw_pkg::req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output stw_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [stw_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [stw_pkg::CfgDataWidth-1:0] cfg_data
);

  stw_pkg::cfg_t cfg;
  stw_pkg::rsp_t walk_rsp;
  logic walk_has_rsp;
  logic req_transfer;

  assign req_ready = !rsp_valid || rsp_ready;
  assign req_transfer = req_valid && req_ready;

  stw_cfg_regs u_cfg (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cfg(cfg)
  );

  stw_walk u_walk (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .transfer(req_transfer),
    .rsp(walk_rsp),
    .has_rsp(walk_has_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req_ready) begin
      rsp_valid <= req_transfer && walk_has_rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (req_transfer && walk_has_rsp) begin
      rsp <= walk_rsp;
    end
  end

endmodule
